/* src/rfbb_pkg.sv */
// shared types, constants and command codes for the flip blend blitter
package rfbb_pkg;

  localparam int IMAGE_WIDTH  = 256;
  localparam int IMAGE_HEIGHT = 256;

  localparam int COORD_W = 8;
  localparam int ADDR_W  = 2 * COORD_W;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;
  localparam int CFG_W   = 9;
  localparam int CIDX_W  = 3;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;
  localparam int ODEPTH = 4;
  localparam int OPTR_W = $clog2(ODEPTH);
  localparam int OCNT_W = OPTR_W + 1;

  // signed geometry math, wide enough for image sizes up to 4096
  localparam int GEO_W = 14;
  localparam logic signed [GEO_W-1:0] IMG_W_S   = GEO_W'(IMAGE_WIDTH);
  localparam logic signed [GEO_W-1:0] IMG_H_S   = GEO_W'(IMAGE_HEIGHT);
  localparam logic signed [GEO_W-1:0] COORD_MAX = GEO_W'((1 << COORD_W) - 1);

  localparam logic [CFG_W-1:0] WEIGHT_FULL = CFG_W'(256);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [CIDX_W-1:0] CFG_RECT_LEFT    = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_RECT_BOTTOM  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_RECT_WIDTH   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_RECT_HEIGHT  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_BLEND_WEIGHT = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_FLIP_MODE    = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_CORNER_TRIM  = 3'd6;

  typedef struct packed {
    logic [COORD_W-1:0] rect_left;
    logic [COORD_W-1:0] rect_bottom;
    logic [8:0]         rect_width;
    logic [8:0]         rect_height;
    logic [8:0]         blend_weight;
    logic [1:0]         flip_mode;
    logic [3:0]         corner_trim;
  } cfg_t;

  typedef struct packed {
    logic              cmd;
    logic              hit;
    logic [ADDR_W-1:0] dst_addr;
    logic [ADDR_W-1:0] src_addr;
    logic [PIX_W-1:0]  pixel;
  } op_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             modified;
  } res_t;

endpackage

/* src/rfbb_ram.sv */
// generic ram, one write port and two registered read ports
module rfbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

/* src/rfbb_front.sv */
// request classifier: rectangle, flip source, corner and image bound checks
module rfbb_front (
  input  rfbb_pkg::cfg_t                 cfg,
  input  logic                           cmd,
  input  logic [rfbb_pkg::COORD_W-1:0]   pos_x,
  input  logic [rfbb_pkg::COORD_W-1:0]   pos_y,
  input  logic [rfbb_pkg::PIX_W-1:0]     pixel,
  output rfbb_pkg::op_t                  op
);

  localparam int GW = rfbb_pkg::GEO_W;

  logic signed [GW-1:0] x, y, left, bottom, wid, hgt, trim;
  logic signed [GW-1:0] j, i, xs, ys;
  logic in_rect, src_ok, corner;
  logic trim_l, trim_r, trim_b, trim_t;

  always_comb begin
    x      = GW'(pos_x);
    y      = GW'(pos_y);
    left   = GW'(cfg.rect_left);
    bottom = GW'(cfg.rect_bottom);
    wid    = GW'(cfg.rect_width);
    hgt    = GW'(cfg.rect_height);
    trim   = GW'(cfg.corner_trim);
    j      = x - left;
    i      = y - bottom;

    in_rect = (cfg.blend_weight != '0) && (wid > 0) && (hgt > 0) &&
              (left < rfbb_pkg::IMG_W_S) && (bottom < rfbb_pkg::IMG_H_S) &&
              (j >= 0) && (j < wid) && (i >= 0) && (i < hgt) &&
              (x < rfbb_pkg::IMG_W_S) && (y < rfbb_pkg::IMG_H_S);

    // mirrored source position inside the rectangle
    xs = cfg.flip_mode[0] ? (left + wid - GW'(1) - j) : x;
    ys = cfg.flip_mode[1] ? (bottom + hgt - GW'(1) - i) : y;

    src_ok = (xs >= 0) && (xs < rfbb_pkg::IMG_W_S) && (xs <= rfbb_pkg::COORD_MAX) &&
             (ys >= 0) && (ys < rfbb_pkg::IMG_H_S) && (ys <= rfbb_pkg::COORD_MAX);

    trim_l = j < trim;
    trim_r = j >= (wid - trim);
    trim_b = i < trim;
    trim_t = i >= (hgt - trim);
    corner = (trim_l && trim_b) || (trim_l && trim_t) ||
             (trim_r && trim_b) || (trim_r && trim_t);

    op.cmd      = cmd;
    op.hit      = in_rect && src_ok && !corner;
    op.dst_addr = {pos_y, pos_x};
    op.src_addr = {ys[rfbb_pkg::COORD_W-1:0], xs[rfbb_pkg::COORD_W-1:0]};
    op.pixel    = pixel;
  end

endmodule

/* src/rfbb_queue.sv */
// short request queue between classifier and frame store side
module rfbb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rfbb_pkg::op_t push_op,
  output logic          not_full,
  input  logic          pop,
  output logic          not_empty,
  output rfbb_pkg::op_t head_op
);

  rfbb_pkg::op_t                 slot_r [rfbb_pkg::QDEPTH];
  logic [rfbb_pkg::QPTR_W-1:0]   wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [rfbb_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign not_full  = cnt_r != rfbb_pkg::QCNT_W'(rfbb_pkg::QDEPTH);
  assign not_empty = cnt_r != '0;
  assign head_op   = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + rfbb_pkg::QCNT_W'(push) - rfbb_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_op;
    end
  end

endmodule

/* src/rfbb_back.sv */
// frame store access, blend pipeline and result fifo
module rfbb_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rfbb_pkg::cfg_t              cfg,
  input  logic                        op_valid,
  input  rfbb_pkg::op_t               op,
  output logic                        op_pop,
  output logic                        res_valid,
  input  logic                        res_ready,
  output rfbb_pkg::res_t              res
);

  localparam int CW = rfbb_pkg::CHAN_W;

  function automatic logic [CW-1:0] mix(input logic [CW-1:0] f, input logic [CW-1:0] o,
                                        input logic [8:0] w);
    logic signed [CW:0]   d;
    logic signed [CW+10:0] p;
    logic signed [CW+10:0] s;
    d = $signed({1'b0, f}) - $signed({1'b0, o});
    p = $signed({1'b0, w}) * d;
    s = $signed({3'b000, o, 8'h00}) + p;
    return s[15:8];
  endfunction

  logic                          is_read, credit_ok, issue;
  logic                          vb_r, hb_r, vc_r;
  logic [rfbb_pkg::PIX_W-1:0]    orig, src;
  logic [8:0]                    w;
  rfbb_pkg::res_t                blend_res, res_c_r;
  rfbb_pkg::res_t                ofifo_r [rfbb_pkg::ODEPTH];
  logic [rfbb_pkg::OPTR_W-1:0]   owptr_r, orptr_r;
  logic [rfbb_pkg::OCNT_W-1:0]   ocnt_r, ocnt_nxt, inflight;
  logic                          res_pop;

  // reads in flight plus fifo fill never exceed fifo depth, so stages b and c never stall
  assign inflight  = rfbb_pkg::OCNT_W'(vb_r) + rfbb_pkg::OCNT_W'(vc_r) + ocnt_r;
  assign credit_ok = inflight < rfbb_pkg::OCNT_W'(rfbb_pkg::ODEPTH);
  assign is_read   = op.cmd == rfbb_pkg::CMD_READ;
  assign issue     = op_valid && (!is_read || credit_ok);
  assign op_pop    = issue;

  rfbb_ram #(
    .WIDTH (rfbb_pkg::PIX_W),
    .DEPTH (rfbb_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (issue && !is_read),
    .waddr   (op.dst_addr),
    .wdata   (op.pixel),
    .raddr_a (op.dst_addr),
    .rdata_a (orig),
    .raddr_b (op.src_addr),
    .rdata_b (src)
  );

  always_comb begin
    w = (cfg.blend_weight > rfbb_pkg::WEIGHT_FULL) ? rfbb_pkg::WEIGHT_FULL : cfg.blend_weight;
    if (hb_r) begin
      blend_res.pixel = {mix(src[23:16], orig[23:16], w),
                         mix(src[15:8],  orig[15:8],  w),
                         mix(src[7:0],   orig[7:0],   w)};
    end else begin
      blend_res.pixel = orig;
    end
    blend_res.modified = hb_r;
  end

  assign res_valid = ocnt_r != '0;
  assign res       = ofifo_r[orptr_r];
  assign res_pop   = res_valid && res_ready;
  assign ocnt_nxt  = ocnt_r + rfbb_pkg::OCNT_W'(vc_r) - rfbb_pkg::OCNT_W'(res_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r    <= 1'b0;
      vc_r    <= 1'b0;
      owptr_r <= '0;
      orptr_r <= '0;
      ocnt_r  <= '0;
    end else begin
      vb_r    <= issue && is_read;
      vc_r    <= vb_r;
      owptr_r <= vc_r ? owptr_r + 1'b1 : owptr_r;
      orptr_r <= res_pop ? orptr_r + 1'b1 : orptr_r;
      ocnt_r  <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hb_r    <= op.hit;
    res_c_r <= blend_res;
    if (vc_r) begin
      ofifo_r[owptr_r] <= res_c_r;
    end
  end

endmodule

/* src/rectangle_flip_blend_blit_core.sv */
// top level of the rectangle flip blend blitter
//
//  port group   dir   handshake            payload
//  in_*         in    in_valid / in_ready  command, pos_x, pos_y, red, green, blue
//  out_*        out   out_valid / out_ready red, green, blue, modified
//  cfg_*        in    cfg_we               cfg_index, cfg_data
//
// one request per cycle sustained while out_ready keeps up; a read needs both read ports
// of the frame store in one cycle, a load its write port. out_valid follows an accepted read
// through the queue, store read, blend and fifo registers. reset empties the request queue
// and result fifo; the frame store is not cleared. out_ready low fills the result fifo, then
// reads stop issuing, the queue fills and in_ready drops.
module rectangle_flip_blend_blit_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_command,
  input  logic [rfbb_pkg::COORD_W-1:0]       in_pos_x,
  input  logic [rfbb_pkg::COORD_W-1:0]       in_pos_y,
  input  logic [rfbb_pkg::CHAN_W-1:0]        in_red,
  input  logic [rfbb_pkg::CHAN_W-1:0]        in_green,
  input  logic [rfbb_pkg::CHAN_W-1:0]        in_blue,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rfbb_pkg::CHAN_W-1:0]        out_red,
  output logic [rfbb_pkg::CHAN_W-1:0]        out_green,
  output logic [rfbb_pkg::CHAN_W-1:0]        out_blue,
  output logic                               out_modified,
  input  logic                               cfg_we,
  input  logic [rfbb_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [rfbb_pkg::CFG_W-1:0]         cfg_data
);

  rfbb_pkg::cfg_t cfg_r, cfg_nxt;
  rfbb_pkg::op_t  front_op, head_op;
  rfbb_pkg::res_t res;
  logic           q_not_full, q_not_empty, q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rfbb_pkg::CFG_RECT_LEFT:    cfg_nxt.rect_left    = cfg_data[7:0];
        rfbb_pkg::CFG_RECT_BOTTOM:  cfg_nxt.rect_bottom  = cfg_data[7:0];
        rfbb_pkg::CFG_RECT_WIDTH:   cfg_nxt.rect_width   = cfg_data;
        rfbb_pkg::CFG_RECT_HEIGHT:  cfg_nxt.rect_height  = cfg_data;
        rfbb_pkg::CFG_BLEND_WEIGHT: cfg_nxt.blend_weight = cfg_data;
        rfbb_pkg::CFG_FLIP_MODE:    cfg_nxt.flip_mode    = cfg_data[1:0];
        rfbb_pkg::CFG_CORNER_TRIM:  cfg_nxt.corner_trim  = cfg_data[3:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rect_left    <= '0;
      cfg_r.rect_bottom  <= '0;
      cfg_r.rect_width   <= '0;
      cfg_r.rect_height  <= '0;
      cfg_r.blend_weight <= rfbb_pkg::WEIGHT_FULL;
      cfg_r.flip_mode    <= 2'd2;
      cfg_r.corner_trim  <= 4'd3;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rfbb_front u_front (
    .cfg   (cfg_r),
    .cmd   (in_command),
    .pos_x (in_pos_x),
    .pos_y (in_pos_y),
    .pixel ({in_red, in_green, in_blue}),
    .op    (front_op)
  );

  assign in_ready = q_not_full;

  rfbb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && q_not_full),
    .push_op   (front_op),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_op   (head_op)
  );

  rfbb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .op_valid  (q_not_empty),
    .op        (head_op),
    .op_pop    (q_pop),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_red      = res.pixel[23:16];
  assign out_green    = res.pixel[15:8];
  assign out_blue     = res.pixel[7:0];
  assign out_modified = res.modified;

endmodule

/* src/rfbb_checker.sv */
// port-level checks for the blitter top level, with bind
module rfbb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rfbb_pkg::CHAN_W-1:0]  out_red,
  input logic [rfbb_pkg::CHAN_W-1:0]  out_green,
  input logic [rfbb_pkg::CHAN_W-1:0]  out_blue,
  input logic                         out_modified
);

  // nothing left over in the result fifo after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // request queue is empty after reset
  assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("in_ready low right after reset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green) &&
                               $stable(out_blue) && $stable(out_modified))
    else $error("stalled result changed");

endmodule

bind rectangle_flip_blend_blit_core rfbb_checker u_rfbb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_red      (out_red),
  .out_green    (out_green),
  .out_blue     (out_blue),
  .out_modified (out_modified)
);

/* tb/blit_pixel_checker.sv */
// checker for the flip blend blitter: predicts every read from the requests it sees
`timescale 1ns / 1ps
module blit_pixel_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_command,
  input  logic [rfbb_pkg::COORD_W-1:0]  in_pos_x,
  input  logic [rfbb_pkg::COORD_W-1:0]  in_pos_y,
  input  logic [rfbb_pkg::CHAN_W-1:0]   in_red,
  input  logic [rfbb_pkg::CHAN_W-1:0]   in_green,
  input  logic [rfbb_pkg::CHAN_W-1:0]   in_blue,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [rfbb_pkg::CHAN_W-1:0]   out_red,
  input  logic [rfbb_pkg::CHAN_W-1:0]   out_green,
  input  logic [rfbb_pkg::CHAN_W-1:0]   out_blue,
  input  logic                          out_modified,
  input  logic                          cfg_we,
  input  logic [rfbb_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [rfbb_pkg::CFG_W-1:0]    cfg_data,
  output int                            mismatches,
  output int                            reads_in_flight,
  output int                            blend_hits
);
  import rfbb_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              modified;
  } blit_px_t;

  logic [PIX_W-1:0]   frame_copy [DEPTH];
  logic [COORD_W-1:0] reg_left;
  logic [COORD_W-1:0] reg_bottom;
  logic [8:0]         reg_width;
  logic [8:0]         reg_height;
  logic [8:0]         reg_weight;
  logic [1:0]         reg_flip;
  logic [3:0]         reg_trim;
  blit_px_t           expected_px [$];
  blit_px_t           want;
  blit_px_t           seen;

  task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] got_val);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_val, got_val);
    mismatches++;
  endtask

  function automatic logic [CHAN_W-1:0] blend8(input int flipped, input int orig,
                                               input int w);
    return CHAN_W'((w * flipped + (256 - w) * orig) >> 8);
  endfunction

  function automatic blit_px_t blit_pixel(input logic [COORD_W-1:0] px,
                                          input logic [COORD_W-1:0] py);
    blit_px_t         r;
    logic [PIX_W-1:0] orig;
    logic [PIX_W-1:0] src;
    int x, y, lft, bot, wid, hgt, w, c, j, i, xs, ys;
    bit corner;
    x    = int'(px);
    y    = int'(py);
    lft  = int'(reg_left);
    bot  = int'(reg_bottom);
    wid  = int'(reg_width);
    hgt  = int'(reg_height);
    c    = int'(reg_trim);
    w    = (reg_weight > WEIGHT_FULL) ? 256 : int'(reg_weight);
    j    = x - lft;
    i    = y - bot;
    orig = frame_copy[{py, px}];
    r    = {orig, 1'b0};
    if (w > 0 && wid > 0 && hgt > 0 && lft < IMAGE_WIDTH && bot < IMAGE_HEIGHT &&
        j >= 0 && j < wid && i >= 0 && i < hgt && x < IMAGE_WIDTH && y < IMAGE_HEIGHT) begin
      xs = reg_flip[0] ? lft + wid - 1 - j : x;
      ys = reg_flip[1] ? bot + hgt - 1 - i : y;
      if (xs >= 0 && xs < IMAGE_WIDTH && ys >= 0 && ys < IMAGE_HEIGHT &&
          xs <= 255 && ys <= 255) begin
        corner = (j < c && i < c) || (j < c && i >= hgt - c) ||
                 (j >= wid - c && i < c) || (j >= wid - c && i >= hgt - c);
        if (!corner) begin
          src = frame_copy[{ys[7:0], xs[7:0]}];
          r.red      = blend8(int'(src[23:16]), int'(orig[23:16]), w);
          r.green    = blend8(int'(src[15:8]), int'(orig[15:8]), w);
          r.blue     = blend8(int'(src[7:0]), int'(orig[7:0]), w);
          r.modified = 1'b1;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      // the frame store survives reset, the registers do not
      reg_left   = '0;
      reg_bottom = '0;
      reg_width  = '0;
      reg_height = '0;
      reg_weight = WEIGHT_FULL;
      reg_flip   = 2'd2;
      reg_trim   = 4'd3;
      mismatches = 0;
      blend_hits = 0;
      expected_px.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RECT_LEFT:    reg_left   = cfg_data[7:0];
          CFG_RECT_BOTTOM:  reg_bottom = cfg_data[7:0];
          CFG_RECT_WIDTH:   reg_width  = cfg_data;
          CFG_RECT_HEIGHT:  reg_height = cfg_data;
          CFG_BLEND_WEIGHT: reg_weight = cfg_data;
          CFG_FLIP_MODE:    reg_flip   = cfg_data[1:0];
          CFG_CORNER_TRIM:  reg_trim   = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_command == CMD_LOAD) begin
          frame_copy[{in_pos_y, in_pos_x}] = {in_red, in_green, in_blue};
        end else begin
          want = blit_pixel(in_pos_x, in_pos_y);
          if (want.modified) blend_hits++;
          expected_px.push_back(want);
        end
      end
      if (out_valid && out_ready) begin
        seen = {out_red, out_green, out_blue, out_modified};
        if (expected_px.size() == 0) begin
          report_mismatch("unexpected result", 32'(0), 32'(seen));
        end else begin
          want = expected_px.pop_front();
          if (seen.red !== want.red)
            report_mismatch("red", 32'(want.red), 32'(seen.red));
          if (seen.green !== want.green)
            report_mismatch("green", 32'(want.green), 32'(seen.green));
          if (seen.blue !== want.blue)
            report_mismatch("blue", 32'(want.blue), 32'(seen.blue));
          if (seen.modified !== want.modified)
            report_mismatch("modified", 32'(want.modified), 32'(seen.modified));
        end
      end
    end
    reads_in_flight = expected_px.size();
  end

endmodule

/* tb/rectangle_flip_blend_blit_core_tb.sv */
// stimulus and verdict for the rectangle flip blend blitter
`timescale 1ns / 1ps
module rectangle_flip_blend_blit_core_tb;
  import rfbb_pkg::*;

  localparam int ITEMS       = 1320;
  localparam int HOLD_CYCLES = 300;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_command;
  logic [COORD_W-1:0]   in_pos_x;
  logic [COORD_W-1:0]   in_pos_y;
  logic [CHAN_W-1:0]    in_red;
  logic [CHAN_W-1:0]    in_green;
  logic [CHAN_W-1:0]    in_blue;
  logic                 out_valid;
  logic                 out_ready;
  logic [CHAN_W-1:0]    out_red;
  logic [CHAN_W-1:0]    out_green;
  logic [CHAN_W-1:0]    out_blue;
  logic                 out_modified;
  logic                 cfg_we;
  logic [CIDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   mismatches;
  int                   reads_in_flight;
  int                   blend_hits;

  // stimulus-side view of the geometry, used to preload mirrored sources
  int  cur_left, cur_bottom, cur_width, cur_height;
  int  n_items, n_loads, n_reads, n_settings;
  bit  loaded [DEPTH];
  logic [ADDR_W-1:0] loaded_addrs [$];
  bit  src_idle_en;
  bit  sink_idle_en;
  bit  long_hold;

  rectangle_flip_blend_blit_core uut (.*);
  blit_pixel_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #20ms;
    $display("rectangle_flip_blend_blit_core_tb: done, errors");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin : result_sink
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 9);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  task automatic send_req(input logic cmd, input logic [COORD_W-1:0] x, y,
                          input logic [PIX_W-1:0] px);
    int gap;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_pos_x   <= x;
    in_pos_y   <= y;
    in_red     <= px[23:16];
    in_green   <= px[15:8];
    in_blue    <= px[7:0];
    do @(posedge clk); while (!in_ready);
    n_items++;
    if (cmd == CMD_LOAD) n_loads++;
    else n_reads++;
  endtask

  task automatic load_px(input logic [COORD_W-1:0] x, y, input logic [PIX_W-1:0] px);
    send_req(CMD_LOAD, x, y, px);
    if (!loaded[{y, x}]) begin
      loaded[{y, x}] = 1'b1;
      loaded_addrs.push_back({y, x});
    end
  endtask

  task automatic ensure_loaded(input logic [COORD_W-1:0] x, y);
    if (!loaded[{y, x}]) load_px(x, y, PIX_W'($urandom));
  endtask

  // every store entry a read may touch is loaded first
  task automatic read_px(input logic [COORD_W-1:0] x, y);
    int xi, yi, xm, ym;
    xi = int'(x);
    yi = int'(y);
    xm = 2 * cur_left + cur_width - 1 - xi;
    ym = 2 * cur_bottom + cur_height - 1 - yi;
    ensure_loaded(x, y);
    if (xi >= cur_left && xi < cur_left + cur_width &&
        yi >= cur_bottom && yi < cur_bottom + cur_height) begin
      if (xm <= 255) ensure_loaded(8'(xm), y);
      if (ym <= 255) ensure_loaded(x, 8'(ym));
      if (xm <= 255 && ym <= 255) ensure_loaded(8'(xm), 8'(ym));
    end
    send_req(CMD_READ, x, y, PIX_W'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (reads_in_flight != 0);
    // loads give no result and may still be in the pipe
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
  endtask

  task automatic set_regs(input int l, b, w, h, wt, f, c);
    drain();
    write_reg(CFG_RECT_LEFT, l);
    write_reg(CFG_RECT_BOTTOM, b);
    write_reg(CFG_RECT_WIDTH, w);
    write_reg(CFG_RECT_HEIGHT, h);
    write_reg(CFG_BLEND_WEIGHT, wt);
    write_reg(CFG_FLIP_MODE, f);
    write_reg(CFG_CORNER_TRIM, c);
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_left   = l;
    cur_bottom = b;
    cur_width  = w;
    cur_height = h;
    n_settings++;
  endtask

  function automatic int pick_span();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 256;
      2:       return 1;
      default: return $urandom_range(2, 40);
    endcase
  endfunction

  initial begin : stimulus
    int pidx, sel, phase_end, wt;
    bit quiet;
    logic [ADDR_W-1:0] a;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_command <= CMD_LOAD;
    in_pos_x   <= '0;
    in_pos_y   <= '0;
    in_red     <= '0;
    in_green   <= '0;
    in_blue    <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_RECT_LEFT;
    cfg_data   <= '0;
    cur_left   = 0;
    cur_bottom = 0;
    cur_width  = 0;
    cur_height = 0;
    n_items    = 0;
    n_loads    = 0;
    n_reads    = 0;
    n_settings = 0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    long_hold    = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: rectangle disabled, pixels pass through
    load_px(8'd0, 8'd0, 24'h000000);
    load_px(8'd255, 8'd255, 24'hffffff);
    read_px(8'd0, 8'd0);
    read_px(8'd255, 8'd255);
    // full replace, both flips, trimmed corners
    set_regs(4, 4, 8, 8, 256, 3, 2);
    read_px(8'd4, 8'd4);
    read_px(8'd11, 8'd11);
    read_px(8'd6, 8'd4);
    read_px(8'd7, 8'd8);
    // rectangle past the right edge, weight above full saturates
    set_regs(248, 250, 12, 3, 300, 1, 0);
    read_px(8'd253, 8'd251);
    read_px(8'd250, 8'd251);
    // zero weight leaves the image alone
    set_regs(0, 0, 256, 256, 0, 3, 0);
    read_px(8'd100, 8'd37);

    pidx = 0;
    while (n_items < ITEMS) begin
      case (pidx)
        0: set_regs(255, 255, 256, 256, 511, 3, 15);
        1: set_regs(0, 0, 0, 0, 0, 0, 0);
        2: set_regs(0, 0, 256, 256, 256, 3, 0);
        3: set_regs(16, 16, 16, 16, 128, 3, 1);
        default: begin
          case ($urandom_range(0, 5))
            0:       wt = 0;
            1:       wt = 256;
            2:       wt = $urandom_range(257, 511);
            default: wt = $urandom_range(1, 255);
          endcase
          set_regs($urandom_range(0, 255), $urandom_range(0, 255), pick_span(),
                   pick_span(), wt, $urandom_range(0, 3), $urandom_range(0, 15));
        end
      endcase
      quiet        = n_items > ITEMS - 250;
      src_idle_en  = !quiet && $urandom_range(0, 3) != 0;
      sink_idle_en = !quiet && $urandom_range(0, 3) != 0;
      if (pidx == 3) begin
        // results blocked for a long stretch while reads keep coming
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        long_hold    = 1'b1;
        repeat (48) read_px(8'(16 + $urandom_range(0, 15)), 8'(16 + $urandom_range(0, 15)));
      end
      phase_end = n_items + $urandom_range(40, 100);
      while (n_items < phase_end) begin
        sel = $urandom_range(0, 99);
        if (sel < 50 && cur_width > 0 && cur_height > 0) begin
          read_px(8'(cur_left + $urandom_range(0, cur_width - 1)),
                  8'(cur_bottom + $urandom_range(0, cur_height - 1)));
        end else if (sel < 65) begin
          read_px(8'($urandom), 8'($urandom));
        end else if (sel < 90 && loaded_addrs.size() > 0) begin
          a = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
          load_px(a[7:0], a[15:8], PIX_W'($urandom));
        end else begin
          load_px(8'($urandom), 8'($urandom), PIX_W'($urandom));
        end
      end
      pidx++;
    end

    drain();
    repeat (10) @(posedge clk);
    $display("run covered %0d requests (%0d loads, %0d reads), %0d blended pixels, %0d settings",
             n_items, n_loads, n_reads, blend_hits, n_settings);
    if (mismatches == 0 && reads_in_flight == 0) begin
      $display("rectangle_flip_blend_blit_core_tb: done, clean");
    end else begin
      $display("rectangle_flip_blend_blit_core_tb: done, errors");
    end
    $finish;
  end

endmodule
